// File: hw/rtl/y2b_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// y2b_pkg
// Shared types and constants of the YCbCr 4:2:0 to BMP byte stream writer.
// ----------------------------------------------------------------------------
package y2b_pkg;

  // Header layout
  localparam int unsigned HDR_LEN   = 54;
  localparam int unsigned CNT_W     = 6;
  localparam logic [7:0]  MAGIC_LO  = 8'h42;   // 'B'
  localparam logic [7:0]  MAGIC_HI  = 8'h4d;   // 'M'
  localparam logic [31:0] HDR_OFFS  = 32'd54;  // pixel data offset
  localparam logic [31:0] INFO_SIZE = 32'd40;  // info header size
  localparam logic [15:0] PLANES    = 16'd1;
  localparam logic [15:0] BPP       = 16'd24;
  localparam logic [31:0] PPM       = 32'd3000;

  // Configuration port
  localparam int unsigned APB_ADDR_W = 3;
  localparam logic        REG_WIDTH  = 1'b0;
  localparam logic        REG_HEIGHT = 1'b1;
  localparam int unsigned RST_WIDTH  = 640;
  localparam int unsigned RST_HEIGHT = 480;

  // Pixel with resolved chroma and position flags
  typedef struct packed {
    logic [7:0] y;
    logic [7:0] cb;
    logic [7:0] cr;
    logic       hdr;
    logic [1:0] pad;
    logic       img_end;
  } pix_t;

  // Converted pixel ready for byte emission
  typedef struct packed {
    logic [7:0] b;
    logic [7:0] g;
    logic [7:0] r;
    logic       hdr;
    logic [1:0] pad;
    logic       img_end;
  } item_t;

  // Image-dependent header words
  typedef struct packed {
    logic [31:0] fsize;
    logic [31:0] width;
    logic [31:0] negh;
  } hdr_info_t;

  typedef enum logic [2:0] {
    PH_HDR = 3'b001,
    PH_COL = 3'b010,
    PH_PAD = 3'b100
  } phase_e;

  // Byte idx of the 54-byte header, little endian
  function automatic logic [7:0] header_byte(logic [CNT_W-1:0] idx, hdr_info_t h);
    logic [CNT_W-1:0] base;
    logic [31:0]      w;
    logic [7:0]       res;
    base = idx - CNT_W'(2);
    unique case (base[CNT_W-1:2])
      4'd0:    w = h.fsize;
      4'd2:    w = HDR_OFFS;
      4'd3:    w = INFO_SIZE;
      4'd4:    w = h.width;
      4'd5:    w = h.negh;
      4'd6:    w = {BPP, PLANES};
      4'd9:    w = PPM;
      4'd10:   w = PPM;
      default: w = 32'd0;
    endcase
    if (idx < CNT_W'(2)) begin
      res = idx[0] ? MAGIC_HI : MAGIC_LO;
    end else begin
      res = w[8*base[1:0] +: 8];
    end
    return res;
  endfunction

endpackage

// File: hw/rtl/y2b_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// y2b_front
// Input register: tracks column and row, holds chroma over column pairs and
// flags header, row padding and end of image for each pixel.
// ----------------------------------------------------------------------------
module y2b_front #(
  parameter int unsigned DIM_BITS = 12
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [DIM_BITS-1:0] width_i,
  input  logic [DIM_BITS-1:0] height_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [7:0]          luma_i,
  input  logic [7:0]          chroma_blue_i,
  input  logic [7:0]          chroma_red_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output y2b_pkg::pix_t       out_pix_o
);

  logic [DIM_BITS-1:0] col_q, col_d, row_q, row_d;
  logic [7:0]          hb_q, hb_d, hr_q, hr_d;
  logic                vld_q, vld_d;
  y2b_pkg::pix_t       pix_q, pix_d;
  logic                accept, even, row_end, img_end;

  assign in_stall_o = vld_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign even       = !col_q[0];

  // Position flags
  assign row_end = ({1'b0, col_q} + (DIM_BITS+1)'(1)) >= {1'b0, width_i};
  assign img_end = row_end && (({1'b0, row_q} + (DIM_BITS+1)'(1)) >= {1'b0, height_i});

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    hb_d  = hb_q;
    hr_d  = hr_q;
    pix_d = pix_q;
    vld_d = vld_q;
    if (accept) begin
      // Latch chroma on even columns
      if (even) begin
        hb_d = chroma_blue_i;
        hr_d = chroma_red_i;
      end
      // Advance position
      if (row_end) begin
        col_d = '0;
        row_d = img_end ? '0 : row_q + DIM_BITS'(1);
      end else begin
        col_d = col_q + DIM_BITS'(1);
      end
      pix_d.y       = luma_i;
      pix_d.cb      = even ? chroma_blue_i : hb_q;
      pix_d.cr      = even ? chroma_red_i : hr_q;
      pix_d.hdr     = (col_q == '0) && (row_q == '0);
      pix_d.pad     = row_end ? width_i[1:0] : 2'd0;  // 3*w pads to 4 by w mod 4
      pix_d.img_end = img_end;
      vld_d         = 1'b1;
    end else if (!out_stall_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      hb_q  <= '0;
      hr_q  <= '0;
      vld_q <= 1'b0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      hb_q  <= hb_d;
      hr_q  <= hr_d;
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pix_q <= pix_d;
  end

  assign out_valid_o = vld_q;
  assign out_pix_o   = pix_q;

endmodule

// File: hw/rtl/y2b_convert.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// y2b_convert
// Color stage: YCbCr to B, G, R with Q8 coefficients, floor and clamp.
// ----------------------------------------------------------------------------
module y2b_convert (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  y2b_pkg::pix_t  in_pix_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output y2b_pkg::item_t out_item_o
);

  localparam logic signed [10:0] K_CB_B = 11'sd435;
  localparam logic signed [10:0] K_CB_G = 11'sd77;
  localparam logic signed [10:0] K_CR_G = 11'sd179;
  localparam logic signed [10:0] K_CR_R = 11'sd358;

  // Floor divide by 256 and clamp to 0..255
  function automatic logic [7:0] to_byte(logic signed [19:0] t);
    logic signed [11:0] v;
    logic [7:0]         res;
    v = t[19:8];
    if (v[11]) begin
      res = 8'd0;
    end else if (v > 12'sd255) begin
      res = 8'hff;
    end else begin
      res = v[7:0];
    end
    return res;
  endfunction

  logic               vld_q, vld_d;
  y2b_pkg::item_t     item_q, item_d;
  logic signed [7:0]  cb_s, cr_s;
  logic signed [19:0] y_s, t_b, t_g, t_r;
  logic               accept;

  assign in_stall_o = vld_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  // Offset chroma by 128: flip the top bit
  assign cb_s = $signed({~in_pix_i.cb[7], in_pix_i.cb[6:0]});
  assign cr_s = $signed({~in_pix_i.cr[7], in_pix_i.cr[6:0]});
  assign y_s  = $signed({4'b0, in_pix_i.y, 8'b0});

  assign t_b = y_s + K_CB_B * cb_s;
  assign t_g = y_s - K_CB_G * cb_s - K_CR_G * cr_s;
  assign t_r = y_s + K_CR_R * cr_s;

  always_comb begin
    item_d = item_q;
    vld_d  = vld_q;
    if (accept) begin
      item_d.b       = to_byte(t_b);
      item_d.g       = to_byte(t_g);
      item_d.r       = to_byte(t_r);
      item_d.hdr     = in_pix_i.hdr;
      item_d.pad     = in_pix_i.pad;
      item_d.img_end = in_pix_i.img_end;
      vld_d          = 1'b1;
    end else if (!out_stall_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign out_valid_o = vld_q;
  assign out_item_o  = item_q;

endmodule

// File: hw/rtl/y2b_emit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// y2b_emit
// Byte sequencer: walks header, B, G, R and row padding of one pixel and
// drives the registered output word.
// ----------------------------------------------------------------------------
module y2b_emit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  y2b_pkg::hdr_info_t  hdr_info_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  y2b_pkg::item_t      in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [7:0]          out_byte_o,
  output logic                last_of_item_o,
  output logic                last_of_image_o
);

  localparam int unsigned CW = y2b_pkg::CNT_W;

  logic                itm_vld_q, itm_vld_d;
  y2b_pkg::item_t      itm_q, itm_d;
  y2b_pkg::phase_e     ph_q, ph_d, ph_n;
  logic [CW-1:0]       cnt_q, cnt_d, cnt_n;
  logic                ov_q, ov_d;
  logic [7:0]          ob_q, ob_d, byte_n;
  logic                oli_q, oli_d, olm_q, olm_d;
  logic                emit_en, fin, load;

  assign emit_en    = itm_vld_q && (!ov_q || !out_stall_i);
  assign in_stall_o = itm_vld_q && !(emit_en && fin);
  assign load       = in_valid_i && !in_stall_o;

  // Select the byte at the current position and the next position
  always_comb begin
    byte_n = 8'd0;
    fin    = 1'b0;
    ph_n   = ph_q;
    cnt_n  = cnt_q + CW'(1);
    unique case (ph_q)
      y2b_pkg::PH_HDR: begin
        byte_n = y2b_pkg::header_byte(cnt_q, hdr_info_i);
        if (cnt_q == CW'(y2b_pkg::HDR_LEN - 1)) begin
          ph_n  = y2b_pkg::PH_COL;
          cnt_n = '0;
        end
      end
      y2b_pkg::PH_COL: begin
        unique case (cnt_q[1:0])
          2'd0:    byte_n = itm_q.b;
          2'd1:    byte_n = itm_q.g;
          default: byte_n = itm_q.r;
        endcase
        if (cnt_q[1:0] == 2'd2) begin
          cnt_n = '0;
          if (itm_q.pad == 2'd0) begin
            fin = 1'b1;
          end else begin
            ph_n = y2b_pkg::PH_PAD;
          end
        end
      end
      y2b_pkg::PH_PAD: begin
        byte_n = 8'd0;
        fin    = (cnt_q[1:0] == itm_q.pad - 2'd1);
      end
      default: begin
        fin = 1'b1;
      end
    endcase
  end

  // Item slot and position
  always_comb begin
    itm_d     = itm_q;
    itm_vld_d = itm_vld_q;
    ph_d      = ph_q;
    cnt_d     = cnt_q;
    if (load) begin
      itm_d     = in_item_i;
      itm_vld_d = 1'b1;
      ph_d      = in_item_i.hdr ? y2b_pkg::PH_HDR : y2b_pkg::PH_COL;
      cnt_d     = '0;
    end else if (emit_en) begin
      if (fin) begin
        itm_vld_d = 1'b0;
      end
      ph_d  = ph_n;
      cnt_d = cnt_n;
    end
  end

  // Output word register
  always_comb begin
    ov_d  = ov_q;
    ob_d  = ob_q;
    oli_d = oli_q;
    olm_d = olm_q;
    if (emit_en) begin
      ov_d  = 1'b1;
      ob_d  = byte_n;
      oli_d = fin;
      olm_d = fin && itm_q.img_end;
    end else if (!out_stall_i) begin
      ov_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      itm_vld_q <= 1'b0;
      ph_q      <= y2b_pkg::PH_COL;
      cnt_q     <= '0;
      ov_q      <= 1'b0;
    end else begin
      itm_vld_q <= itm_vld_d;
      ph_q      <= ph_d;
      cnt_q     <= cnt_d;
      ov_q      <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    itm_q <= itm_d;
    ob_q  <= ob_d;
    oli_q <= oli_d;
    olm_q <= olm_d;
  end

  assign out_valid_o     = ov_q;
  assign out_byte_o      = ob_q;
  assign last_of_item_o  = oli_q;
  assign last_of_image_o = olm_q;

endmodule

// File: hw/rtl/ycbcr420_to_bmp_stream.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ycbcr420_to_bmp_stream
// Turns a raster stream of YCbCr 4:2:0 pixels into the bytes of a top-down
// 24-bit BMP file: 54-byte header, then B, G, R per pixel, rows padded to 4.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-------------------------------
//  in      | input     | in_valid_i/in_stall_o  | luma_i, chroma_blue_i/red_i
//  out     | output    | out_valid_o/out_stall_i| out_byte_o, last_of_item_o,
//          |           |                        | last_of_image_o
//  cfg     | APB slave | psel/penable/pready    | paddr, pwdata, prdata
//
//  A pixel is three bytes on the output, one byte per cycle while the output
//  does not stall, plus the 54-byte header on the first pixel of an image and
//  0..3 padding bytes at row end; the byte-wide output port sets this rate.
//  Input words pass the front, color, item slot and output byte registers.
//  Reset clears position counters, held chroma and all valid flags;
//  registers return to width 640 and height 480.
//  A stall on the output backs up through three buffered stages.
// ----------------------------------------------------------------------------
module ycbcr420_to_bmp_stream #(
  parameter int unsigned DIM_BITS = 12
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Configuration
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [y2b_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  // Pixel input
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [7:0]                      luma_i,
  input  logic [7:0]                      chroma_blue_i,
  input  logic [7:0]                      chroma_red_i,
  // Byte output
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [7:0]                      out_byte_o,
  output logic                            last_of_item_o,
  output logic                            last_of_image_o
);

  localparam int unsigned RB_W = DIM_BITS + 2;
  localparam int unsigned PR_W = DIM_BITS + RB_W;

  logic [DIM_BITS-1:0] width_q, width_d, height_q, height_d;
  logic [RB_W-1:0]     row_bytes;
  logic [PR_W-1:0]     prod;
  logic [31:0]         fsize_q, fsize_d;
  logic                cfg_wr;
  y2b_pkg::hdr_info_t  hdr_info;

  logic                front_vld, conv_stall, conv_vld, emit_stall;
  y2b_pkg::pix_t       front_pix;
  y2b_pkg::item_t      conv_item;

  // Register writes
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    if (cfg_wr) begin
      unique case (paddr[2])
        y2b_pkg::REG_WIDTH:  width_d  = pwdata[DIM_BITS-1:0];
        y2b_pkg::REG_HEIGHT: height_d = pwdata[DIM_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Register reads
  always_comb begin
    unique case (paddr[2])
      y2b_pkg::REG_WIDTH:  prdata = 32'(width_q);
      y2b_pkg::REG_HEIGHT: prdata = 32'(height_q);
      default:             prdata = 32'd0;
    endcase
  end

  // File size: height * row bytes + header, modulo 2^32
  assign row_bytes = ((RB_W'(width_q) * RB_W'(3)) + RB_W'(3)) & ~RB_W'(3);
  assign prod      = PR_W'(height_q) * PR_W'(row_bytes);
  assign fsize_d   = 32'(prod) + y2b_pkg::HDR_OFFS;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DIM_BITS'(y2b_pkg::RST_WIDTH);
      height_q <= DIM_BITS'(y2b_pkg::RST_HEIGHT);
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fsize_q <= fsize_d;
  end

  assign hdr_info.fsize = fsize_q;
  assign hdr_info.width = 32'(width_q);
  assign hdr_info.negh  = 32'd0 - 32'(height_q);

  y2b_front #(
    .DIM_BITS (DIM_BITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .width_i       (width_q),
    .height_i      (height_q),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .luma_i        (luma_i),
    .chroma_blue_i (chroma_blue_i),
    .chroma_red_i  (chroma_red_i),
    .out_valid_o   (front_vld),
    .out_stall_i   (conv_stall),
    .out_pix_o     (front_pix)
  );

  y2b_convert u_convert (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (front_vld),
    .in_stall_o  (conv_stall),
    .in_pix_i    (front_pix),
    .out_valid_o (conv_vld),
    .out_stall_i (emit_stall),
    .out_item_o  (conv_item)
  );

  y2b_emit u_emit (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .hdr_info_i      (hdr_info),
    .in_valid_i      (conv_vld),
    .in_stall_o      (emit_stall),
    .in_item_i       (conv_item),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_byte_o      (out_byte_o),
    .last_of_item_o  (last_of_item_o),
    .last_of_image_o (last_of_image_o)
  );

  // End of file always closes a pixel
  a_last_image_ends_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_of_image_o |-> last_of_item_o)
    else $error("last_of_image without last_of_item");

  // Input stalls only when the front register is full
  a_stall_needs_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> front_vld)
    else $error("input stalled with empty front register");

  // A stalled front word is kept for the next cycle
  a_front_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    front_vld && conv_stall |=> front_vld)
    else $error("front word lost under stall");

  // Output stalls back up into the color stage
  a_conv_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    conv_vld && emit_stall |=> conv_vld && $stable(conv_item))
    else $error("color stage word changed under stall");

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the YCbCr to BMP byte stream writer. A predictor
// tracks row/column position, held chroma and the two size registers, and
// builds the expected header, pixel and padding bytes for every accepted
// input word. Each output word is compared field by field against the oldest
// expected byte. Directed tests cover reset values, clamping, chroma reuse,
// degenerate and maximum sizes, and register changes in mid-image; a random
// test then runs many small images with random input gaps and output stalls.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned DIM_BITS = 12;
  localparam logic [31:0] DIM_MASK = (32'd1 << DIM_BITS) - 32'd1;
  localparam logic [y2b_pkg::APB_ADDR_W-1:0] ADDR_WIDTH  = {y2b_pkg::REG_WIDTH, 2'b00};
  localparam logic [y2b_pkg::APB_ADDR_W-1:0] ADDR_HEIGHT = {y2b_pkg::REG_HEIGHT, 2'b00};
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned CYCLE_LIMIT   = 10_000_000;
  localparam int unsigned RANDOM_PIXELS = 135;

  typedef struct packed {
    logic [7:0] value;
    logic       item_end;
    logic       image_end;
  } bmp_byte_t;

  // DUT signals
  logic                           clk;
  logic                           rst_n;
  logic                           psel;
  logic                           penable;
  logic                           pwrite;
  logic [y2b_pkg::APB_ADDR_W-1:0] paddr;
  logic [31:0]                    pwdata;
  logic [31:0]                    prdata;
  logic                           pready;
  logic                           in_valid;
  logic                           in_stall;
  logic [7:0]                     luma;
  logic [7:0]                     chroma_blue;
  logic [7:0]                     chroma_red;
  logic                           out_valid;
  logic                           out_stall;
  logic [7:0]                     out_byte;
  logic                           last_of_item;
  logic                           last_of_image;

  // Predictor state
  logic [31:0] cfg_width;
  logic [31:0] cfg_height;
  int unsigned pos_col;
  int unsigned pos_row;
  int          held_cb;
  int          held_cr;
  bmp_byte_t   bmp_bytes_due[$];

  int unsigned fail_count;
  int unsigned cycle_count;
  int unsigned stall_left;
  logic        steady;

  ycbcr420_to_bmp_stream #(
    .DIM_BITS(DIM_BITS)
  ) u_top (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .luma_i         (luma),
    .chroma_blue_i  (chroma_blue),
    .chroma_red_i   (chroma_red),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .out_byte_o     (out_byte),
    .last_of_item_o (last_of_item),
    .last_of_image_o(last_of_image)
  );

  // Clock and reset
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Gap length: mostly none or short, a few long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Floor by 256, then clamp to a byte
  function automatic logic [7:0] to_channel(int t);
    int v;
    v = t >>> 8;
    if (v < 0) return 8'd0;
    if (v > 255) return 8'd255;
    return v[7:0];
  endfunction

  task automatic push_le(logic [31:0] v, int unsigned n);
    bmp_byte_t b;
    for (int unsigned i = 0; i < n; i++) begin
      b = '{value: v[8*i +: 8], item_end: 1'b0, image_end: 1'b0};
      bmp_bytes_due.push_back(b);
    end
  endtask

  // Expected bytes for one accepted pixel; advance the position
  task automatic predict_pixel(logic [7:0] y, logic [7:0] cb, logic [7:0] cr);
    logic [31:0] row_len;
    int          yi;
    int          cbo;
    int          cro;
    logic        row_end;
    logic        image_end;
    int unsigned pad;
    if (pos_col == 0 && pos_row == 0) begin
      row_len = (cfg_width * 32'd3 + 32'd3) & ~32'd3;
      push_le({16'd0, y2b_pkg::MAGIC_HI, y2b_pkg::MAGIC_LO}, 2);
      push_le(cfg_height * row_len + y2b_pkg::HDR_LEN, 4);
      push_le(32'd0, 4);
      push_le(y2b_pkg::HDR_OFFS, 4);
      push_le(y2b_pkg::INFO_SIZE, 4);
      push_le(cfg_width, 4);
      push_le(32'd0 - cfg_height, 4);
      push_le({16'd0, y2b_pkg::PLANES}, 2);
      push_le({16'd0, y2b_pkg::BPP}, 2);
      push_le(32'd0, 4);
      push_le(32'd0, 4);
      push_le(y2b_pkg::PPM, 4);
      push_le(y2b_pkg::PPM, 4);
      push_le(32'd0, 4);
      push_le(32'd0, 4);
    end
    // Latch chroma on even columns only
    if (pos_col % 2 == 0) begin
      held_cb = int'(cb);
      held_cr = int'(cr);
    end
    yi  = int'(y);
    cbo = held_cb - 128;
    cro = held_cr - 128;
    push_le({24'd0, to_channel(256 * yi + 435 * cbo)}, 1);
    push_le({24'd0, to_channel(256 * yi - 77 * cbo - 179 * cro)}, 1);
    push_le({24'd0, to_channel(256 * yi + 358 * cro)}, 1);
    row_end   = (pos_col + 1) >= cfg_width;
    image_end = row_end && ((pos_row + 1) >= cfg_height);
    if (row_end) begin
      pad = (4 - ((cfg_width * 3) & 3)) & 3;
      push_le(32'd0, pad);
      pos_col = 0;
      pos_row = image_end ? 0 : ((pos_row + 1) & DIM_MASK);
    end else begin
      pos_col = (pos_col + 1) & DIM_MASK;
    end
    bmp_bytes_due[bmp_bytes_due.size() - 1].item_end  = 1'b1;
    bmp_bytes_due[bmp_bytes_due.size() - 1].image_end = image_end;
  endtask

  // Send one pixel word after a random gap; predict on acceptance
  task automatic send_pixel(logic [7:0] y, logic [7:0] cb, logic [7:0] cr);
    int unsigned gap;
    gap = steady ? 0 : pick_gap();
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid    <= 1'b1;
    luma        <= y;
    chroma_blue <= cb;
    chroma_red  <= cr;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    predict_pixel(y, cb, cr);
  endtask

  // Drop valid, wait out every expected byte, then let the pipe settle
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (bmp_bytes_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic check_reg(logic [y2b_pkg::APB_ADDR_W-1:0] addr, logic [31:0] want);
    @(negedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    paddr   <= addr;
    @(negedge clk);
    penable <= 1'b1;
    forever begin
      @(posedge clk);
      if (pready) break;
    end
    if (prdata !== want) begin
      $error("prdata at 0x%0h: expected %0d, got %0d", addr, want, prdata);
      fail_count++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Write a size register while idle, then read it back
  task automatic write_reg(logic [y2b_pkg::APB_ADDR_W-1:0] addr, logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= addr;
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    forever begin
      @(posedge clk);
      if (pready) break;
    end
    if (addr == ADDR_WIDTH) cfg_width = value & DIM_MASK;
    else cfg_height = value & DIM_MASK;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    check_reg(addr, (addr == ADDR_WIDTH) ? cfg_width : cfg_height);
  endtask

  // Reset values, then a register change in mid-image
  task automatic test_defaults();
    check_reg(ADDR_WIDTH, y2b_pkg::RST_WIDTH);
    check_reg(ADDR_HEIGHT, y2b_pkg::RST_HEIGHT);
    send_pixel(8'd90, 8'd60, 8'd200);
    send_pixel(8'd170, 8'd1, 8'd2);
    drain();
    // column is now 2: width 3 ends the row, height 1 the image
    write_reg(ADDR_WIDTH, 32'd3);
    write_reg(ADDR_HEIGHT, 32'd1);
    send_pixel(8'd33, 8'd140, 8'd110);
    drain();
  endtask

  // Clamping at both ends, one-pixel images with padding
  task automatic test_extremes();
    write_reg(ADDR_WIDTH, 32'd1);
    write_reg(ADDR_HEIGHT, 32'd1);
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd128, 8'd128, 8'd128);
    drain();
  endtask

  // Odd columns reuse the chroma of the even column before them
  task automatic test_chroma_reuse();
    write_reg(ADDR_WIDTH, 32'd4);
    write_reg(ADDR_HEIGHT, 32'd2);
    for (int i = 0; i < 8; i++) begin
      send_pixel(8'(40 + 25 * i), 8'(i * 37), 8'(255 - i * 29));
    end
    drain();
  endtask

  // Zero width and height, upper pwdata bits ignored
  task automatic test_zero_sizes();
    write_reg(ADDR_WIDTH, 32'hFFFF_F000);
    write_reg(ADDR_HEIGHT, 32'h0001_0000);
    send_pixel(8'd16, 8'd240, 8'd16);
    send_pixel(8'd235, 8'd16, 8'd240);
    send_pixel(8'd77, 8'd128, 8'd0);
    drain();
  endtask

  // Largest sizes, then shrink them mid-image to finish it
  task automatic test_max_sizes();
    write_reg(ADDR_WIDTH, 32'd4095);
    write_reg(ADDR_HEIGHT, 32'd4095);
    send_pixel(8'd200, 8'd10, 8'd250);
    send_pixel(8'd5, 8'd99, 8'd3);
    drain();
    write_reg(ADDR_WIDTH, 32'd2);
    send_pixel(8'd64, 8'd192, 8'd64);
    drain();
    write_reg(ADDR_HEIGHT, 32'd1);
    send_pixel(8'd128, 8'd50, 8'd220);
    send_pixel(8'd250, 8'd180, 8'd20);
    drain();
  endtask

  // Random sizes and pixels, whole and partial images
  task automatic test_random_images();
    int unsigned sent;
    int unsigned w;
    int unsigned h;
    int unsigned r;
    int unsigned count;
    sent = 0;
    while (sent < RANDOM_PIXELS) begin
      r = $urandom_range(0, 99);
      if (r < 5) w = 0;
      else if (r < 88) w = $urandom_range(1, 9);
      else w = $urandom_range(10, 40);
      h = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4);
      if ($urandom_range(0, 4) != 0) write_reg(ADDR_WIDTH, w);
      if ($urandom_range(0, 4) != 0) write_reg(ADDR_HEIGHT, h);
      count = ((cfg_width == 0) ? 1 : cfg_width) * ((cfg_height == 0) ? 1 : cfg_height);
      if ($urandom_range(0, 9) < 3) count = $urandom_range(1, count);
      if (count > 30) count = 30;
      steady = ($urandom_range(0, 4) == 0);
      for (int unsigned i = 0; i < count; i++) begin
        if ($urandom_range(0, 9) == 0) begin
          send_pixel(($urandom_range(0, 1) != 0) ? 8'd255 : 8'd0,
                     ($urandom_range(0, 1) != 0) ? 8'd255 : 8'd0,
                     ($urandom_range(0, 1) != 0) ? 8'd255 : 8'd0);
        end else begin
          send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
        end
      end
      sent += count;
      drain();
      steady = 1'b0;
    end
  endtask

  // Output stall: random bursts, none started while steady
  always @(negedge clk) begin
    if (stall_left != 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (!steady && $urandom_range(0, 2) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= pick_gap();
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Compare each accepted output word against the oldest expected byte
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (bmp_bytes_due.size() == 0) begin
        $error("unexpected output word: out_byte %0d", out_byte);
        fail_count++;
      end else begin
        if (out_byte !== bmp_bytes_due[0].value) begin
          $error("out_byte: expected %0d, got %0d", bmp_bytes_due[0].value, out_byte);
          fail_count++;
        end
        if (last_of_item !== bmp_bytes_due[0].item_end) begin
          $error("last_of_item: expected %0d, got %0d",
                 bmp_bytes_due[0].item_end, last_of_item);
          fail_count++;
        end
        if (last_of_image !== bmp_bytes_due[0].image_end) begin
          $error("last_of_image: expected %0d, got %0d",
                 bmp_bytes_due[0].image_end, last_of_image);
          fail_count++;
        end
        void'(bmp_bytes_due.pop_front());
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    rst_n       = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    in_valid    = 1'b0;
    luma        = '0;
    chroma_blue = '0;
    chroma_red  = '0;
    out_stall   = 1'b0;
    stall_left  = 0;
    steady      = 1'b0;
    fail_count  = 0;
    cycle_count = 0;
    cfg_width   = y2b_pkg::RST_WIDTH;
    cfg_height  = y2b_pkg::RST_HEIGHT;
    pos_col     = 0;
    pos_row     = 0;
    held_cb     = 0;
    held_cr     = 0;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    test_defaults();
    test_extremes();
    test_chroma_reuse();
    test_zero_sizes();
    test_max_sizes();
    test_random_images();
    drain();

    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
